@@ sv/slab_object_allocator_unit_macros.svh @@
// Assertion macros shared by the checker files
`ifndef SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked every cycle outside reset
`define SOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/soa_pkg.sv @@
// ---------------------------------------------------------------------------
// soa_pkg
// Shared sizes and codes of the slab object allocator.
// ---------------------------------------------------------------------------
package soa_pkg;
    localparam int NumSlabs   = 16;
    localparam int MaxObjects = 64;
    localparam int SlabW      = $clog2(NumSlabs);
    localparam int ObjW       = $clog2(MaxObjects);
    localparam int LinkW      = SlabW + 1;
    localparam int NfoDepth   = NumSlabs * MaxObjects;
    localparam int NfoAw      = SlabW + ObjW;
    localparam int CntW       = 7;
    localparam int SlabCntW   = 5;
    localparam int UsedW      = 11;
    localparam int CfgW       = 7;
    localparam int CfgIdxW    = 1;
    localparam logic [LinkW-1:0] Nil = LinkW'(NumSlabs);

    localparam logic [1:0] ClsFree    = 2'd0;
    localparam logic [1:0] ClsPartial = 2'd1;
    localparam logic [1:0] ClsFull    = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNoSlot  = 2'd1;
    localparam logic [1:0] StBadFree = 2'd2;

    localparam logic [CfgIdxW-1:0] RegObjPerSlab = 1'b0;
    localparam logic [CfgIdxW-1:0] RegMaxFree    = 1'b1;

    localparam logic ReqAlloc = 1'b0;
    localparam logic ReqFree  = 1'b1;
endpackage

@@ sv/soa_ram.sv @@
// ---------------------------------------------------------------------------
// soa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module soa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/slab_object_allocator_unit.sv @@
// Steps: alloc from an existing slab goes PICK, RD, TAKE, RECL, DONE; free goes
//   PICK, RD, RECL, TRIM (repeated while free slabs are released), DONE; alloc
//   that creates a slab first writes its free list in BUILD through the single
//   write port of the link memory; a bad free or a full pool goes PICK, DONE.
// Requests: one word at a time, taken in the cycle after the previous result is
//   loaded; a result still waiting in the output register holds the following
//   word in its last step.
// Reset: synchronous active-low; all slots unused, lists empty, counts zero.
// ---------------------------------------------------------------------------
// slab_object_allocator_unit
// Slab allocator: per-slab metadata in flops, object links in one RAM.
// ---------------------------------------------------------------------------
module slab_object_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_req_type,
    input  logic [3:0]                   i_free_slab_index,
    input  logic [5:0]                   i_free_object_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [3:0]                   o_slab_index,
    output logic [5:0]                   o_object_index,
    output logic [10:0]                  o_used_objects,
    output logic [4:0]                   o_live_slabs,
    output logic [4:0]                   o_free_slabs,
    input  logic                         i_cfg_we,
    input  logic [soa_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [soa_pkg::CfgW-1:0]     i_cfg_data
);
    localparam int SW = soa_pkg::SlabW;
    localparam int OW = soa_pkg::ObjW;
    localparam int LW = soa_pkg::LinkW;
    localparam int NS = soa_pkg::NumSlabs;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PICK  = 8'b0000_0010,
        S_BUILD = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_TAKE  = 8'b0001_0000,
        S_RECL  = 8'b0010_0000,
        S_TRIM  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [6:0] r_ops;
    logic [4:0] r_maxf;

    // per-slab metadata
    logic [6:0]    r_fhead [NS];
    logic [6:0]    r_fcnt  [NS];
    logic [NS-1:0] r_live;
    logic [1:0]    r_cls   [NS];
    logic [6:0]    r_cap   [NS];
    logic [LW-1:0] r_prev  [NS];
    logic [LW-1:0] r_next  [NS];
    logic [LW-1:0] r_head  [3];
    logic [4:0]    r_ccnt  [3];
    logic [10:0]   r_used;

    // working registers
    logic          r_req;
    logic [SW-1:0] r_s;
    logic [OW-1:0] r_obj;
    logic [6:0]    r_i;
    logic [1:0]    r_st;

    // output word
    logic        r_ovalid;
    logic [1:0]  r_ost;
    logic [3:0]  r_osl;
    logic [5:0]  r_oob;
    logic [10:0] r_oused;
    logic [4:0]  r_olive, r_ofree;

    // link memory
    logic                      m_we;
    logic [soa_pkg::NfoAw-1:0] m_waddr, m_raddr;
    logic [6:0]                m_wdata, m_rdata;

    soa_ram #(.Width(7), .Depth(soa_pkg::NfoDepth)) u_nfo (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    // lowest unused slot
    logic [LW-1:0] lo_free;
    always_comb begin
        lo_free = soa_pkg::Nil;
        for (int k = NS - 1; k >= 0; k--) begin
            if (!r_live[k]) lo_free = LW'(k);
        end
    end

    // clamped capacity
    logic [6:0] cap_c;
    always_comb begin
        cap_c = r_ops;
        if (r_ops == 7'd0) cap_c = 7'd1;
        if (r_ops > 7'(soa_pkg::MaxObjects)) cap_c = 7'(soa_pkg::MaxObjects);
    end

    // desired class of the working slab
    logic [1:0] want;
    always_comb begin
        if (r_fcnt[r_s] == 7'd0) want = soa_pkg::ClsFull;
        else if (r_fcnt[r_s] >= r_cap[r_s]) want = soa_pkg::ClsFree;
        else want = soa_pkg::ClsPartial;
    end

    logic [OW-1:0] take_obj;
    assign take_obj = (r_fhead[r_s] >= 7'(soa_pkg::MaxObjects)) ? '0 : r_fhead[r_s][OW-1:0];

    logic bad_free;
    assign bad_free = !r_live[i_free_slab_index[SW-1:0]] ||
                      (7'(i_free_object_index) >= r_cap[i_free_slab_index[SW-1:0]]);

    logic [5:0] ssum;
    assign ssum = 6'(r_ccnt[0]) + 6'(r_ccnt[1]) + 6'(r_ccnt[2]);

    logic out_free;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    // link memory port control
    always_comb begin
        m_we    = 1'b0;
        m_waddr = {r_s, r_i[OW-1:0]};
        m_wdata = r_i + 7'd1;
        m_raddr = {r_s, take_obj};
        if (r_state == S_BUILD) m_we = 1'b1;
        if (r_state == S_RD && r_req == soa_pkg::ReqFree) begin
            m_we    = 1'b1;
            m_waddr = {r_s, r_obj};
            m_wdata = r_fhead[r_s];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PICK;
            S_PICK:  n_state = (r_st != soa_pkg::StOk) ? S_DONE :
                               (r_req == soa_pkg::ReqFree) ? S_RD :
                               (r_head[soa_pkg::ClsPartial] < soa_pkg::Nil ||
                                r_head[soa_pkg::ClsFree] < soa_pkg::Nil) ? S_RD :
                               (lo_free == soa_pkg::Nil) ? S_DONE : S_BUILD;
            S_BUILD: if (r_i + 7'd1 >= cap_c) n_state = S_RD;
            S_RD:    n_state = (r_req == soa_pkg::ReqFree) ? S_RECL : S_TAKE;
            S_TAKE:  n_state = S_RECL;
            S_RECL:  n_state = (r_req == soa_pkg::ReqFree) ? S_TRIM : S_DONE;
            S_TRIM:  if (!(r_ccnt[soa_pkg::ClsFree] > r_maxf &&
                           r_head[soa_pkg::ClsFree] < soa_pkg::Nil)) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        logic [LW-1:0] p, n, h, rr;
        logic [1:0]    c;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ops    <= 7'd64;
            r_maxf   <= 5'd5;
            r_live   <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= soa_pkg::Nil;
                r_ccnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            // output word valid: loaded in the last step, cleared on handoff
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    soa_pkg::RegObjPerSlab: r_ops  <= i_cfg_data;
                    soa_pkg::RegMaxFree:    r_maxf <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req_type;
                        r_s   <= i_free_slab_index[SW-1:0];
                        r_obj <= i_free_object_index;
                        r_i   <= '0;
                        r_st  <= (i_req_type == soa_pkg::ReqFree && bad_free) ?
                                 soa_pkg::StBadFree : soa_pkg::StOk;
                    end
                end
                S_PICK: begin
                    if (r_st == soa_pkg::StOk && r_req == soa_pkg::ReqAlloc) begin
                        if (r_head[soa_pkg::ClsPartial] < soa_pkg::Nil)
                            r_s <= r_head[soa_pkg::ClsPartial][SW-1:0];
                        else if (r_head[soa_pkg::ClsFree] < soa_pkg::Nil)
                            r_s <= r_head[soa_pkg::ClsFree][SW-1:0];
                        else if (lo_free == soa_pkg::Nil) begin
                            r_st  <= soa_pkg::StNoSlot;
                            r_s   <= '0;
                            r_obj <= '0;
                        end else begin
                            // new slab pushed on the free list
                            rr = lo_free;
                            h  = r_head[soa_pkg::ClsFree];
                            r_s <= rr[SW-1:0];
                            r_cap[rr[SW-1:0]]   <= cap_c;
                            r_fhead[rr[SW-1:0]] <= '0;
                            r_fcnt[rr[SW-1:0]]  <= cap_c;
                            r_live[rr[SW-1:0]]  <= 1'b1;
                            r_prev[rr[SW-1:0]]  <= soa_pkg::Nil;
                            r_next[rr[SW-1:0]]  <= h;
                            r_cls[rr[SW-1:0]]   <= soa_pkg::ClsFree;
                            r_head[soa_pkg::ClsFree] <= rr;
                            r_ccnt[soa_pkg::ClsFree] <= r_ccnt[soa_pkg::ClsFree] + 5'd1;
                        end
                    end
                end
                S_BUILD: r_i <= r_i + 7'd1;
                S_RD: begin
                    if (r_req == soa_pkg::ReqFree) begin
                        r_fhead[r_s] <= 7'(r_obj);
                        if (r_fcnt[r_s] < 7'd127) r_fcnt[r_s] <= r_fcnt[r_s] + 7'd1;
                        if (r_used != '0) r_used <= r_used - 11'd1;
                    end else begin
                        r_obj <= take_obj;
                    end
                end
                S_TAKE: begin
                    r_fhead[r_s] <= m_rdata;
                    if (r_fcnt[r_s] != '0) r_fcnt[r_s] <= r_fcnt[r_s] - 7'd1;
                    r_used <= r_used + 11'd1;
                end
                S_RECL: begin
                    if (want != r_cls[r_s]) begin
                        c = r_cls[r_s];
                        p = r_prev[r_s];
                        n = r_next[r_s];
                        h = r_head[want];
                        // unlink
                        if (p < soa_pkg::Nil) r_next[p[SW-1:0]] <= n;
                        else r_head[c] <= n;
                        if (n < soa_pkg::Nil) r_prev[n[SW-1:0]] <= p;
                        // push (head may have been the node just unlinked)
                        if (p == soa_pkg::Nil && c == want) h = n;
                        r_prev[r_s] <= soa_pkg::Nil;
                        r_next[r_s] <= h;
                        if (h < soa_pkg::Nil) r_prev[h[SW-1:0]] <= LW'(r_s);
                        r_head[want] <= LW'(r_s);
                        r_cls[r_s] <= want;
                        if (c == want) begin
                            if (r_ccnt[c] == '0) r_ccnt[c] <= 5'd1;
                        end else begin
                            if (r_ccnt[c] != '0) r_ccnt[c] <= r_ccnt[c] - 5'd1;
                            r_ccnt[want] <= r_ccnt[want] + 5'd1;
                        end
                    end
                end
                S_TRIM: begin
                    if (r_ccnt[soa_pkg::ClsFree] > r_maxf &&
                        r_head[soa_pkg::ClsFree] < soa_pkg::Nil) begin
                        rr = r_head[soa_pkg::ClsFree];
                        n  = r_next[rr[SW-1:0]];
                        r_head[soa_pkg::ClsFree] <= n;
                        if (n < soa_pkg::Nil) r_prev[n[SW-1:0]] <= soa_pkg::Nil;
                        r_ccnt[soa_pkg::ClsFree] <= r_ccnt[soa_pkg::ClsFree] - 5'd1;
                        r_live[rr[SW-1:0]] <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ost    <= r_st;
                        r_osl    <= 4'(r_s);
                        r_oob    <= 6'(r_obj);
                        r_oused  <= r_used;
                        r_olive  <= ssum[4:0];
                        r_ofree  <= r_ccnt[soa_pkg::ClsFree];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ost;
    assign o_slab_index   = r_osl;
    assign o_object_index = r_oob;
    assign o_used_objects = r_oused;
    assign o_live_slabs   = r_olive;
    assign o_free_slabs   = r_ofree;
endmodule

@@ sv/soa_checker.sv @@
// ---------------------------------------------------------------------------
// soa_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "slab_object_allocator_unit_macros.svh"
module soa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [3:0] o_slab_index,
    input logic [5:0] o_object_index,
    input logic [4:0] o_live_slabs,
    input logic [4:0] o_free_slabs
);
    `SOA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `SOA_ASSERT_IMP(a_stat, i_clk, i_rst_n, o_valid, o_status <= soa_pkg::StBadFree)
    `SOA_ASSERT_IMP(a_free_le_live, i_clk, i_rst_n, o_valid, o_free_slabs <= o_live_slabs)
    `SOA_ASSERT_IMP(a_noslot, i_clk, i_rst_n, o_valid && o_status == soa_pkg::StNoSlot, o_slab_index == 4'd0 && o_object_index == 6'd0 && o_live_slabs == 5'(soa_pkg::NumSlabs))
endmodule

bind slab_object_allocator_unit soa_checker u_soa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_status(o_status), .o_slab_index(o_slab_index), .o_object_index(o_object_index),
    .o_live_slabs(o_live_slabs), .o_free_slabs(o_free_slabs)
);
